// File: hdl/sxg_pkg.sv
// Shared types and constants for the horizontal Sobel gradient stream.
`default_nettype none
package sxg_pkg;

  localparam int PIX_W = 8;
  localparam int ROW_W = 12;
  localparam int COL_W = 11;
  localparam int LW_W  = 12;
  localparam int IH_W  = 13;
  localparam int CFG_W = 13;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam int LINE_WIDTH_RST   = 640;
  localparam int IMAGE_HEIGHT_RST = 480;
  localparam int HEIGHT_LIMIT     = 4096;
  localparam int MIN_DIM          = 3;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] gradient;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } res_t;

endpackage
`default_nettype wire

// File: hdl/sobel_x_gradient_stream.sv
// Top level: streaming 3x3 horizontal Sobel gradient with two line buffers.
`default_nettype none
// Accepts one 8-bit pixel per cycle in raster order and returns clamped
// horizontal gradients tagged with row and column via the compute stage and
// the result batch. Border results are zero and the last result of an image
// carries image_done. Row 0 returns no results. Below it a pixel returns one
// result (none at column 0, two at a row's last column), and on the last row
// every pixel adds one more zero result, so its last pixel returns three. The
// rate is one pixel per cycle except where a pixel yields several results or
// out_stall holds the output: the single result port drains them one per
// cycle and in_stall holds the input meanwhile. A configuration write restarts
// the image; write it only while no item is in flight.
module sobel_x_gradient_stream
  import sxg_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [PIX_W-1:0]   in_pixel,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [PIX_W-1:0]        out_gradient,
  output logic [ROW_W-1:0]        out_row,
  output logic [COL_W-1:0]        out_col,
  output logic                    out_image_done
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RST_LAST_COL =
    (LINE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH - 1 : LINE_WIDTH_RST - 1;
  localparam int RST_LAST_ROW = IMAGE_HEIGHT_RST - 1;

  // effective last column / last row
  logic [CW-1:0]    last_col_r, last_col_nxt;
  logic [ROW_W-1:0] last_row_r, last_row_nxt;
  logic             restart;

  // input counters
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             in_accept;

  // compute stage
  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_lastcol_r;
  logic             s1_lastrow_r;
  logic [PIX_W-1:0] top_r;
  logic [PIX_W-1:0] mid_r;
  logic             s1_fire;

  logic [PIX_W-1:0] older_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [PIX_W-1:0] win_r   [6];
  logic [PIX_W-1:0] win_nxt [6];

  logic signed [10:0] grad_sum;
  logic [PIX_W-1:0]   grad;

  // result batch
  res_t       bat_r   [3];
  res_t       bat_nxt [3];
  res_t       ld      [3];
  logic [1:0] ld_cnt;
  logic [1:0] bat_cnt_r, bat_cnt_nxt;
  logic [1:0] bat_head_r, bat_head_nxt;
  logic       out_take;
  res_t       head_res;

  // configuration
  always_comb begin
    logic [31:0] v;
    last_col_nxt = last_col_r;
    last_row_nxt = last_row_r;
    restart      = 1'b0;
    v            = '0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_WIDTH: begin
          v = {20'd0, cfg_data[LW_W-1:0]};
          if (v < 32'(MIN_DIM)) begin
            last_col_nxt = CW'(MIN_DIM - 1);
          end else if (v > 32'(MAX_WIDTH)) begin
            last_col_nxt = CW'(MAX_WIDTH - 1);
          end else begin
            last_col_nxt = CW'(v - 32'd1);
          end
          restart = 1'b1;
        end
        CFG_IMAGE_HEIGHT: begin
          v = {19'd0, cfg_data[IH_W-1:0]};
          if (v < 32'(MIN_DIM)) begin
            last_row_nxt = ROW_W'(MIN_DIM - 1);
          end else if (v > 32'(HEIGHT_LIMIT)) begin
            last_row_nxt = ROW_W'(HEIGHT_LIMIT - 1);
          end else begin
            last_row_nxt = ROW_W'(v - 32'd1);
          end
          restart = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  // input side
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_accept) begin
      if (col_r == last_col_r) begin
        col_nxt = '0;
        row_nxt = (row_r == last_row_r) ? '0 : row_r + 12'd1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix_r     <= in_pixel;
      s1_col_r     <= col_r;
      s1_row_r     <= row_r;
      s1_lastcol_r <= (col_r == last_col_r);
      s1_lastrow_r <= (row_r == last_row_r);
    end
  end

  // line buffers: read on accept, write back when the item leaves the stage
  always_ff @(posedge clk) begin
    if (in_accept) begin
      top_r <= older_mem[col_r];
      mid_r <= middle_mem[col_r];
    end
    if (s1_fire) begin
      older_mem[s1_col_r]  <= mid_r;
      middle_mem[s1_col_r] <= s1_pix_r;
    end
  end

  // gradient
  assign grad_sum = ($signed({3'b000, top_r}) - $signed({3'b000, win_r[0]}))
                  + (($signed({3'b000, mid_r}) - $signed({3'b000, win_r[1]})) <<< 1)
                  + ($signed({3'b000, s1_pix_r}) - $signed({3'b000, win_r[2]}));

  always_comb begin
    if (s1_row_r < 12'd2 || s1_col_r < CW'(2)) begin
      grad = '0;
    end else if (grad_sum < 11'sd0) begin
      grad = '0;
    end else if (grad_sum > $signed({3'b000, PIX_MAX})) begin
      grad = PIX_MAX;
    end else begin
      grad = grad_sum[PIX_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (s1_fire) begin
      win_nxt[0] = win_r[3];
      win_nxt[1] = win_r[4];
      win_nxt[2] = win_r[5];
      win_nxt[3] = top_r;
      win_nxt[4] = mid_r;
      win_nxt[5] = s1_pix_r;
    end
  end

  // results caused by the item in the compute stage
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ld[i] = '0;
    end
    ld_cnt = '0;
    if (s1_row_r != '0) begin
      if (s1_col_r != '0) begin
        ld[ld_cnt].gradient = grad;
        ld[ld_cnt].row      = s1_row_r - 12'd1;
        ld[ld_cnt].col      = COL_W'(s1_col_r - CW'(1));
        ld[ld_cnt].done     = 1'b0;
        ld_cnt              = ld_cnt + 2'd1;
      end
      if (s1_lastcol_r) begin
        ld[ld_cnt].gradient = '0;
        ld[ld_cnt].row      = s1_row_r - 12'd1;
        ld[ld_cnt].col      = COL_W'(s1_col_r);
        ld[ld_cnt].done     = 1'b0;
        ld_cnt              = ld_cnt + 2'd1;
      end
    end
    if (s1_lastrow_r) begin
      ld[ld_cnt].gradient = '0;
      ld[ld_cnt].row      = s1_row_r;
      ld[ld_cnt].col      = COL_W'(s1_col_r);
      ld[ld_cnt].done     = s1_lastcol_r;
      ld_cnt              = ld_cnt + 2'd1;
    end
  end

  // result batch, drained one per cycle while out_stall is low
  assign out_valid = (bat_cnt_r != '0);
  assign out_take  = out_valid && !out_stall;
  assign s1_fire   = s1_valid_r &&
                     ((bat_cnt_r == 2'd0) || ((bat_cnt_r == 2'd1) && out_take));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bat_nxt[i] = bat_r[i];
    end
    bat_cnt_nxt  = bat_cnt_r;
    bat_head_nxt = bat_head_r;
    if (s1_fire) begin
      for (int i = 0; i < 3; i++) begin
        bat_nxt[i] = ld[i];
      end
      bat_cnt_nxt  = ld_cnt;
      bat_head_nxt = '0;
    end else if (out_take) begin
      bat_cnt_nxt  = bat_cnt_r - 2'd1;
      bat_head_nxt = bat_head_r + 2'd1;
    end
  end

  always_comb begin
    case (bat_head_r)
      2'd0:    head_res = bat_r[0];
      2'd1:    head_res = bat_r[1];
      2'd2:    head_res = bat_r[2];
      default: head_res = bat_r[0];
    endcase
  end

  assign out_gradient   = head_res.gradient;
  assign out_row        = head_res.row;
  assign out_col        = head_res.col;
  assign out_image_done = head_res.done;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      bat_r[i] <= bat_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= CW'(RST_LAST_COL);
      last_row_r <= ROW_W'(RST_LAST_ROW);
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      bat_cnt_r  <= '0;
      bat_head_r <= '0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      last_col_r <= last_col_nxt;
      last_row_r <= last_row_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
      bat_cnt_r  <= bat_cnt_nxt;
      bat_head_r <= bat_head_nxt;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/sxg_checker.sv
// Port-level checks for the Sobel gradient stream, bound to the top level.
`default_nettype none
module sxg_checker
  import sxg_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [PIX_W-1:0] out_gradient,
  input wire logic [ROW_W-1:0] out_row,
  input wire logic [COL_W-1:0] out_col,
  input wire logic             out_image_done
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_gradient) &&
      $stable(out_row) && $stable(out_col) && $stable(out_image_done))
    else $error("stalled result changed");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_done |-> out_gradient == '0)
    else $error("image_done result not zero");

  a_left_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_col == '0 |-> out_gradient == '0)
    else $error("left border not zero");

  a_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row == '0 |-> out_gradient == '0)
    else $error("top border not zero");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sobel_x_gradient_stream sxg_checker u_sxg_checker (.*);
`default_nettype wire
